>>> rtl/sacl_pkg.sv
// ============================================================================
// sacl_pkg: shared types and constants for the LRU cache simulator
// Field widths, configuration register indexes, outcome codes and the
// command/status bundles between controller and datapath.
// ============================================================================
package sacl_pkg;

  // Port field widths
  localparam int ADDR_FIELD_W = 64;
  localparam int CNT_W        = 32;
  localparam int OUTCOME_W    = 2;

  // Configuration port
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 6;
  localparam int SET_BITS_W   = 4;
  localparam int BLOCK_BITS_W = 6;
  localparam int WAYS_W       = 4;
  // set_bits + block_bits, up to 15 + 63
  localparam int SHIFT_W      = 7;

  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS       = 2'd2;

  // Result codes
  typedef enum logic [OUTCOME_W-1:0] {
    OUTCOME_HIT   = 2'd0,
    OUTCOME_FILL  = 2'd1,
    OUTCOME_EVICT = 2'd2
  } outcome_t;

  // Controller -> datapath
  typedef struct packed {
    logic clear;   // write one zero row of the clearing pass
    logic lookup;  // access transfer: latch address, read its set
    logic commit;  // write back the set, update totals, load result
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic clear_last;  // clearing pass is at its final row
    logic out_free;    // result register can take a new result
  } dp_stat_t;

endpackage

>>> rtl/sacl_if.sv
// ============================================================================
// sacl_if: valid/ready channels of the LRU cache simulator
// Access channel (address in), result channel (outcome and totals out) and
// configuration write channel.
// ============================================================================
interface sacl_access_if import sacl_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ADDR_FIELD_W-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

interface sacl_result_if import sacl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OUTCOME_W-1:0] outcome;
  logic [CNT_W-1:0]     hit_total;
  logic [CNT_W-1:0]     miss_total;
  logic [CNT_W-1:0]     eviction_total;

  modport source (output valid, output outcome, output hit_total, output miss_total,
                  output eviction_total, input ready);
  modport sink   (input valid, input outcome, input hit_total, input miss_total,
                  input eviction_total, output ready);
endinterface

interface sacl_cfg_if import sacl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/sacl_ram.sv
// ============================================================================
// sacl_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/sacl_ctrl.sv
// ============================================================================
// sacl_ctrl: sequencer of the LRU cache simulator
// Runs the clearing pass after reset, then per access: read the set,
// then commit the update once the result register is free.
// ============================================================================
module sacl_ctrl import sacl_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_LOOK  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // commands
  assign in_ready   = (state == ST_IDLE);
  assign cmd.clear  = (state == ST_CLEAR);
  assign cmd.lookup = (state == ST_IDLE) && in_valid;
  assign cmd.commit = (state == ST_LOOK) && stat.out_free;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (stat.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_LOOK;
      end
      ST_LOOK: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

`ifndef ASSERT_OFF
  // an accepted access is looked up in the following cycle
  a_accept_to_look: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_LOOK))
    else $error("access transfer not followed by lookup");

  // a blocked result keeps the pending update waiting
  a_look_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOK && !stat.out_free) |=> (state == ST_LOOK && !in_ready))
    else $error("lookup left while result register was full");
`endif

endmodule

>>> rtl/sacl_dp.sv
// ============================================================================
// sacl_dp: datapath of the LRU cache simulator
// Config registers, address split, set memory (valid, tag and age of every
// way in one row), parallel tag compare, LRU update, totals, result register.
// ============================================================================
module sacl_dp import sacl_pkg::*; #(
  parameter int MAX_SET_BITS = 8,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  dp_cmd_t                 cmd,
  output dp_stat_t                stat,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic [ADDR_FIELD_W-1:0] address,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [OUTCOME_W-1:0]    outcome,
  output logic [CNT_W-1:0]        hit_total,
  output logic [CNT_W-1:0]        miss_total,
  output logic [CNT_W-1:0]        eviction_total
);

  localparam int NUM_SETS  = 1 << MAX_SET_BITS;
  localparam int IDX_W     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int TAG_W     = ADDR_WIDTH - 1;
  localparam int AGE_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WI_W      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_CNT_W = $clog2(MAX_WAYS + 1);
  localparam int LINE_W    = 1 + TAG_W + AGE_W;
  localparam int ROW_W     = MAX_WAYS * LINE_W;
  localparam logic [AGE_W-1:0] AGE_MAX  = AGE_W'(MAX_WAYS - 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_SETS - 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = '1;

  // configuration registers
  logic [SET_BITS_W-1:0]   set_bits;
  logic [BLOCK_BITS_W-1:0] block_bits;
  logic [WAYS_W-1:0]       ways_in_use;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= '0;
      block_bits  <= BLOCK_BITS_W'(1);
      ways_in_use <= WAYS_W'(1);
    end else if (cfg_valid) begin
      if (cfg_index == REG_SET_BITS)   set_bits    <= cfg_data[SET_BITS_W-1:0];
      if (cfg_index == REG_BLOCK_BITS) block_bits  <= cfg_data[BLOCK_BITS_W-1:0];
      if (cfg_index == REG_WAYS)       ways_in_use <= cfg_data[WAYS_W-1:0];
    end
  end

  // effective geometry (out-of-range values clamped)
  logic [SET_BITS_W-1:0]   sb;
  logic [BLOCK_BITS_W-1:0] bb;
  logic [SHIFT_W-1:0]      shamt;
  logic [WAY_CNT_W-1:0]    ways_eff;

  assign sb    = (set_bits > SET_BITS_W'(MAX_SET_BITS)) ? SET_BITS_W'(MAX_SET_BITS) : set_bits;
  assign bb    = (block_bits == '0) ? BLOCK_BITS_W'(1) : block_bits;
  assign shamt = SHIFT_W'(sb) + SHIFT_W'(bb);

  always_comb begin
    if (ways_in_use == '0) begin
      ways_eff = WAY_CNT_W'(1);
    end else if (32'(ways_in_use) > MAX_WAYS) begin
      ways_eff = WAY_CNT_W'(MAX_WAYS);
    end else begin
      ways_eff = WAY_CNT_W'(ways_in_use);
    end
  end

  // address split
  logic [ADDR_WIDTH-1:0] addr_used;
  logic [ADDR_WIDTH-1:0] set_shift;
  logic [ADDR_WIDTH-1:0] tag_shift;
  logic [IDX_W-1:0]      set_mask;
  logic [IDX_W-1:0]      set_idx;

  assign addr_used = address[ADDR_WIDTH-1:0];
  assign set_shift = addr_used >> bb;
  assign tag_shift = addr_used >> shamt;

  always_comb begin
    for (int i = 0; i < IDX_W; i++) begin
      set_mask[i] = (i < 32'(sb));
    end
  end

  assign set_idx = set_shift[IDX_W-1:0] & set_mask;

  // latched access
  logic [IDX_W-1:0] set_q;
  logic [TAG_W-1:0] tag_q;

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      set_q <= set_idx;
      tag_q <= tag_shift[TAG_W-1:0];
    end
  end

  // clearing pass counter
  logic [IDX_W-1:0] clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clear) begin
      clr_idx <= clr_idx + IDX_W'(1);
    end
  end

  assign stat.clear_last = (clr_idx == IDX_LAST);

  // set memory
  logic [ROW_W-1:0] row_rd;
  logic [ROW_W-1:0] row_wr;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata;

  assign ram_we    = cmd.clear || cmd.commit;
  assign ram_waddr = cmd.clear ? clr_idx : set_q;
  assign ram_wdata = cmd.clear ? '0 : row_wr;

  sacl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_set_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.lookup),
    .raddr (set_idx),
    .rdata (row_rd)
  );

  // unpack the set
  logic             line_v [MAX_WAYS];
  logic [TAG_W-1:0] line_t [MAX_WAYS];
  logic [AGE_W-1:0] line_g [MAX_WAYS];
  logic             used   [MAX_WAYS];

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      {line_v[w], line_t[w], line_g[w]} = row_rd[w*LINE_W +: LINE_W];
      used[w] = (WAY_CNT_W'(w) < ways_eff);
    end
  end

  // hit search, first free way, LRU victim
  logic            hit_found;
  logic [WI_W-1:0] hit_way;
  logic            free_found;
  logic [WI_W-1:0] free_way;
  logic [WI_W-1:0] vic_way;

  always_comb begin
    hit_found  = 1'b0;
    hit_way    = '0;
    free_found = 1'b0;
    free_way   = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (!hit_found && used[w] && line_v[w] && line_t[w] == tag_q) begin
        hit_found = 1'b1;
        hit_way   = WI_W'(w);
      end
      if (!free_found && used[w] && !line_v[w]) begin
        free_found = 1'b1;
        free_way   = WI_W'(w);
      end
    end
  end

  // highest rank wins, lowest way on a tie
  always_comb begin
    vic_way = '0;
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (used[w] && line_g[w] > line_g[vic_way]) begin
        vic_way = WI_W'(w);
      end
    end
  end

  // recency update and new row
  logic [WI_W-1:0]  target;
  logic [AGE_W-1:0] ref_rank;
  logic             age_all;
  outcome_t         outcome_c;

  always_comb begin
    if (hit_found) begin
      target    = hit_way;
      ref_rank  = line_g[hit_way];
      age_all   = 1'b0;
      outcome_c = OUTCOME_HIT;
    end else if (free_found) begin
      target    = free_way;
      ref_rank  = '0;
      age_all   = 1'b1;
      outcome_c = OUTCOME_FILL;
    end else begin
      target    = vic_way;
      ref_rank  = line_g[vic_way];
      age_all   = 1'b0;
      outcome_c = OUTCOME_EVICT;
    end
  end

  always_comb begin
    logic             nv;
    logic [TAG_W-1:0] nt;
    logic [AGE_W-1:0] ng;
    for (int w = 0; w < MAX_WAYS; w++) begin
      nv = line_v[w];
      nt = line_t[w];
      ng = line_g[w];
      if (used[w] && line_v[w] && (age_all || line_g[w] < ref_rank) && line_g[w] != AGE_MAX) begin
        ng = line_g[w] + AGE_W'(1);
      end
      if (WI_W'(w) == target) begin
        nv = 1'b1;
        nt = tag_q;
        ng = '0;
      end
      row_wr[w*LINE_W +: LINE_W] = {nv, nt, ng};
    end
  end

  // running totals, saturating
  logic [CNT_W-1:0] hits_seen;
  logic [CNT_W-1:0] misses_seen;
  logic [CNT_W-1:0] evictions_seen;
  logic [CNT_W-1:0] hits_seen_next;
  logic [CNT_W-1:0] misses_seen_next;
  logic [CNT_W-1:0] evictions_seen_next;

  always_comb begin
    hits_seen_next      = hits_seen;
    misses_seen_next    = misses_seen;
    evictions_seen_next = evictions_seen;
    if (outcome_c == OUTCOME_HIT) begin
      if (hits_seen != CNT_MAX) hits_seen_next = hits_seen + CNT_W'(1);
    end else begin
      if (misses_seen != CNT_MAX) misses_seen_next = misses_seen + CNT_W'(1);
    end
    if (outcome_c == OUTCOME_EVICT && evictions_seen != CNT_MAX) begin
      evictions_seen_next = evictions_seen + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hits_seen      <= '0;
      misses_seen    <= '0;
      evictions_seen <= '0;
    end else if (cmd.commit) begin
      hits_seen      <= hits_seen_next;
      misses_seen    <= misses_seen_next;
      evictions_seen <= evictions_seen_next;
    end
  end

  // result register
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      outcome        <= outcome_c;
      hit_total      <= hits_seen_next;
      miss_total     <= misses_seen_next;
      eviction_total <= evictions_seen_next;
    end
  end

`ifndef ASSERT_OFF
  // a committed access always shows up as a pending result
  a_commit_result: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("commit did not load the result register");

  // totals move only on a commit
  a_totals_quiet: assert property (@(posedge clk) disable iff (rst)
    !cmd.commit |=> ($stable(hits_seen) && $stable(misses_seen) && $stable(evictions_seen)))
    else $error("totals changed without a commit");
`endif

endmodule

>>> rtl/set_assoc_cache_lru_sim.sv
// ============================================================================
// set_assoc_cache_lru_sim: set-associative cache simulator with LRU replacement
// Top level: joins the sequencer and the datapath to the three channels.
// ============================================================================
// Usage:
//   cfg    : register writes (0 set_bits, 1 block_bits, 2 ways_in_use); always
//            ready. Write only while no access is in flight.
//   access : one byte address per transfer.
//   result : one transfer per access: outcome (0 hit, 1 fill, 2 eviction) and
//            the saturating hit, miss and eviction totals after that access.
// Accesses do not overlap: a set read from the set memory, then a
//   compare/update/write-back step; the next address is taken only after
//   the write-back, since the next access may hit the row just written.
// Stall: the result register holds a finished result while access accepts
//   the next address; that access then waits in its update cycle until the
//   result register frees.
// Reset: synchronous. A clearing pass then zeroes all 2**MAX_SET_BITS set rows,
//   one row per cycle, with access.ready low; config writes are taken.
// ============================================================================
module set_assoc_cache_lru_sim import sacl_pkg::*; #(
  parameter int MAX_SET_BITS = 8,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 64
) (
  input logic          clk,
  input logic          rst,
  sacl_cfg_if.sink     cfg,
  sacl_access_if.sink  access,
  sacl_result_if.source result
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  sacl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (access.valid),
    .in_ready (access.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  sacl_dp #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .ADDR_WIDTH   (ADDR_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_valid      (cfg.valid),
    .cfg_ready      (cfg.ready),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .address        (access.address),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .outcome        (result.outcome),
    .hit_total      (result.hit_total),
    .miss_total     (result.miss_total),
    .eviction_total (result.eviction_total)
  );

endmodule
